@@ rtl/core/dwvs_pkg.sv @@
// ----------------------------------------------------------------------------
// dwvs_pkg
// Shared constants for the deque with value search: widths, default depth,
// request action codes and result status codes.
// ----------------------------------------------------------------------------
package dwvs_pkg;

  localparam int DATA_W      = 32;
  localparam int DEPTH_DEF   = 16;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 2;
  localparam int FOUND_W     = 4;
  localparam int OCC_W       = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

endpackage

@@ rtl/core/dwvs_ram.sv @@
// ----------------------------------------------------------------------------
// dwvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dwvs_ram #(
  parameter int WIDTH = dwvs_pkg::DATA_W,
  parameter int DEPTH = dwvs_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/deque_with_value_search_core.sv @@
// ----------------------------------------------------------------------------
// deque_with_value_search_core
// Bounded double-ended queue of signed 32-bit values kept in a RAM ring,
// with push/pop at either end and a linear search from the front.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request item: in_action and
//   in_value. Output channel (out_valid/out_stall) returns exactly one result
//   item per request: status, popped data, found index, occupancy, empty flag.
//   The block holds one request at a time; in_stall is high while it works.
//   A push, a full push, an empty pop and unused codes go from accept
//   straight to S_DONE; a pop first passes through S_READ. A search reads
//   one ring entry per cycle through the single RAM read port, in S_SCAN,
//   until a match or until all n held entries have been compared.
//   A new request is taken only once the last result has left S_DONE.
//   A finished result sits in the output register; a new request is taken
//   meanwhile, and its result waits in the core while out_stall is high.
//   Reset clears the front pointer and the count: the queue comes up empty and
//   ready on the first cycle after reset. RAM contents need no clearing.
// ----------------------------------------------------------------------------
module deque_with_value_search_core #(
  parameter int DEPTH = dwvs_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dwvs_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [dwvs_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dwvs_pkg::STATUS_W-1:0]       out_status,
  output logic signed [dwvs_pkg::DATA_W-1:0]  out_data,
  output logic [dwvs_pkg::FOUND_W-1:0]        out_found_index,
  output logic [dwvs_pkg::OCC_W-1:0]          out_occupancy,
  output logic                                out_is_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_P = (PTR_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [PTR_W-1:0]              front_r, front_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              cmp_r, cmp_nxt;
  logic [PTR_W-1:0]              scan_ptr_r, scan_ptr_nxt;
  logic [dwvs_pkg::DATA_W-1:0]   key_r, key_nxt;
  logic [dwvs_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [dwvs_pkg::DATA_W-1:0]   res_data_r, res_data_nxt;
  logic [CNT_W-1:0]              res_found_r, res_found_nxt;

  logic                          out_valid_r;
  logic [dwvs_pkg::STATUS_W-1:0] out_status_r;
  logic [dwvs_pkg::DATA_W-1:0]   out_data_r;
  logic [dwvs_pkg::FOUND_W-1:0]  out_found_r;
  logic [dwvs_pkg::OCC_W-1:0]    out_occ_r;
  logic                          out_empty_r;

  logic                          ram_we;
  logic [PTR_W-1:0]              ram_waddr;
  logic [PTR_W-1:0]              ram_raddr;
  logic [dwvs_pkg::DATA_W-1:0]   ram_rdata;
  logic                          accept;
  logic                          out_free;
  logic                          is_full;
  logic                          is_empty_q;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_P) begin
      s = s - DEPTH_P;
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_P) ? '0 : p + PTR_W'(1);
  endfunction

  dwvs_ram #(
    .WIDTH (dwvs_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign is_full    = (cnt_r == DEPTH_C);
  assign is_empty_q = (cnt_r == '0);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    cnt_nxt        = cnt_r;
    cmp_nxt        = cmp_r;
    scan_ptr_nxt   = scan_ptr_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_found_nxt  = res_found_r;
    ram_we         = 1'b0;
    ram_waddr      = front_r;
    ram_raddr      = front_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = dwvs_pkg::STAT_OK;
          res_data_nxt   = '0;
          res_found_nxt  = '0;
          key_nxt        = in_value;
          state_nxt      = S_DONE;
          case (in_action)
            dwvs_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                res_status_nxt = dwvs_pkg::STAT_FULL;
              end else begin
                front_nxt = (front_r == '0) ? LAST_P : front_r - PTR_W'(1);
                ram_we    = 1'b1;
                ram_waddr = front_nxt;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            dwvs_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                res_status_nxt = dwvs_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(front_r, PTR_W'(cnt_r));
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            dwvs_pkg::ACT_POP_FRONT: begin
              if (is_empty_q) begin
                res_status_nxt = dwvs_pkg::STAT_EMPTY;
              end else begin
                ram_raddr = front_r;
                front_nxt = ring_inc(front_r);
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_READ;
              end
            end
            dwvs_pkg::ACT_POP_BACK: begin
              if (is_empty_q) begin
                res_status_nxt = dwvs_pkg::STAT_EMPTY;
              end else begin
                ram_raddr = ring_add(front_r, PTR_W'(cnt_r - CNT_W'(1)));
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_READ;
              end
            end
            dwvs_pkg::ACT_SEARCH: begin
              if (is_empty_q) begin
                res_status_nxt = dwvs_pkg::STAT_EMPTY;
              end else begin
                ram_raddr    = front_r;
                scan_ptr_nxt = ring_inc(front_r);
                cmp_nxt      = '0;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_data_nxt = ram_rdata;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        if (ram_rdata == key_r) begin
          res_found_nxt = cmp_r;
          state_nxt     = S_DONE;
        end else if (cmp_r == cnt_r - CNT_W'(1)) begin
          res_status_nxt = dwvs_pkg::STAT_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          ram_raddr    = scan_ptr_r;
          scan_ptr_nxt = ring_inc(scan_ptr_r);
          cmp_nxt      = cmp_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_r        <= cmp_nxt;
    scan_ptr_r   <= scan_ptr_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_found_r  <= res_found_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_found_r  <= dwvs_pkg::FOUND_W'(res_found_r);
      out_occ_r    <= dwvs_pkg::OCC_W'(cnt_r);
      out_empty_r  <= is_empty_q;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data        = out_data_r;
  assign out_found_index = out_found_r;
  assign out_occupancy   = out_occ_r;
  assign out_is_empty    = out_empty_r;

endmodule
